FILE: rtl/gau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gau_pkg;

    localparam int unsigned BLOCK_W = 128;

    // Low terms of the field polynomial x^128 + x^7 + x^2 + x + 1.
    localparam logic [7:0] POLY_LOW = 8'h87;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    typedef struct packed {
        t_block     c_block;   // buffer topped up with the beat's leading bytes
        t_block     l_block;   // bytes left over once a block is complete
        logic [3:0] new_fill;
        logic       full;
        logic       pending;   // buffer holds bytes after this beat
    } t_align;

    // Keeps the leading n bytes of a block, most significant byte first.
    function automatic t_block byte_mask(input logic [4:0] n);
        byte_mask = ~({BLOCK_W{1'b1}} >> {n, 3'b000});
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gau_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gau_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        final_req;

    modport source (output valid, data_high, data_low, byte_count, final_req, input ready);
    modport sink   (input valid, data_high, data_low, byte_count, final_req, output ready);
endinterface

`default_nettype wire

FILE: rtl/gau_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gau_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    modport source (output valid, digest_high, digest_low, input ready);
    modport sink   (input valid, digest_high, digest_low, output ready);
endinterface

`default_nettype wire

FILE: rtl/gau_gf_mult.sv
`timescale 1ns / 1ps
`default_nettype none

// GF(2^128) product in GCM bit order. Operands are bit-reversed so that the
// carry-less product and the fold can be written in ordinary polynomial order.
module gau_gf_mult (
    input  wire gau_pkg::t_block i_a,
    input  wire gau_pkg::t_block i_b,
    output gau_pkg::t_block      o_p
);

    gau_pkg::t_block a_r;
    gau_pkg::t_block b_r;
    logic [254:0]    prod;
    logic [126:0]    hi;
    logic [134:0]    fold1;
    logic [6:0]      top;
    gau_pkg::t_block red;

    always_comb begin
        for (int i = 0; i < 128; i++) begin
            a_r[i] = i_a[127-i];
            b_r[i] = i_b[127-i];
        end

        prod = '0;
        for (int i = 0; i < 128; i++) begin
            if (a_r[i]) begin
                prod = prod ^ ({127'b0, b_r} << i);
            end
        end

        // First fold brings the top 127 bits down, the second clears the few
        // bits that the first one pushed past bit 127.
        hi    = prod[254:128];
        fold1 = '0;
        for (int k = 0; k < 8; k++) begin
            if (gau_pkg::POLY_LOW[k]) begin
                fold1 = fold1 ^ ({8'b0, hi} << k);
            end
        end
        top = fold1[134:128];
        red = prod[127:0] ^ fold1[127:0];
        for (int k = 0; k < 8; k++) begin
            if (gau_pkg::POLY_LOW[k]) begin
                red = red ^ ({121'b0, top} << k);
            end
        end

        for (int i = 0; i < 128; i++) begin
            o_p[i] = red[127-i];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gau_align.sv
`timescale 1ns / 1ps
`default_nettype none

// Merges one beat's bytes with the partial buffer.
module gau_align (
    input  wire gau_pkg::t_block i_partial,
    input  wire [3:0]            i_fill,
    input  wire gau_pkg::t_block i_data,
    input  wire [4:0]            i_count,
    output gau_pkg::t_align      o_align
);

    logic [4:0]      n;
    logic [4:0]      sum;
    logic [4:0]      room;
    gau_pkg::t_block data_m;

    always_comb begin
        // Any count above sixteen means a whole block.
        n      = i_count[4] ? 5'd16 : {1'b0, i_count[3:0]};
        sum    = {1'b0, i_fill} + n;
        room   = 5'd16 - {1'b0, i_fill};
        data_m = i_data & gau_pkg::byte_mask(n);

        o_align.c_block  = i_partial | (data_m >> {i_fill, 3'b000});
        o_align.l_block  = data_m << {room, 3'b000};
        o_align.new_fill = sum[3:0];
        o_align.full     = sum[4];
        o_align.pending  = (sum[3:0] != 4'd0);
    end

endmodule

`default_nettype wire

FILE: rtl/ghash_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// GHASH accumulator. Takes one beat per cycle while input ready is high; a beat
// passes an input register and is then folded into the running digest, and a
// digest is registered at the output as its final beat leaves. Input ready
// only drops while a final beat waits in the input register and the previous
// digest has not yet been taken. A beat may complete one block and, when final,
// leave a padded remainder too: both are absorbed in the same cycle using H and
// H squared, and H squared is worked out and registered at each key write.
module ghash_accumulator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    gau_in_if.sink      i_in,
    gau_out_if.source   o_out
);

    gau_pkg::t_block r_h;
    gau_pkg::t_block r_hsq;
    gau_pkg::t_block n_h;
    gau_pkg::t_block key_sq;

    logic            r_in_valid;
    gau_pkg::t_block r_in_data;
    logic [4:0]      r_in_count;
    logic            r_in_final;

    gau_pkg::t_block r_y;
    gau_pkg::t_block r_partial;
    logic [3:0]      r_fill;

    logic            r_out_valid;
    gau_pkg::t_block r_out_digest;

    gau_pkg::t_align align;
    gau_pkg::t_block mul1_a;
    gau_pkg::t_block mul1_k;
    gau_pkg::t_block mul1_p;
    gau_pkg::t_block mul2_p;
    gau_pkg::t_block n_y;
    logic            use_sq;
    logic            mul_en;
    logic            advance;
    logic            in_ready;

    // Key registers and the square of the key being written.
    always_comb begin
        n_h = r_h;
        unique case (i_cfg_index)
            gau_pkg::CFG_KEY_HIGH: n_h[127:64] = i_cfg_data;
            gau_pkg::CFG_KEY_LOW:  n_h[63:0]   = i_cfg_data;
            default:               n_h         = r_h;
        endcase
    end

    gau_gf_mult u_key_sq (
        .i_a (n_h),
        .i_b (n_h),
        .o_p (key_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= '0;
            r_hsq <= '0;
        end else if (i_cfg_we) begin
            r_h   <= n_h;
            r_hsq <= key_sq;
        end
    end

    // Handshake control.
    always_comb begin
        advance  = r_in_valid && (!r_in_final || !r_out_valid || o_out.ready);
        in_ready = !r_in_valid || advance;
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_data  <= {i_in.data_high, i_in.data_low};
            r_in_count <= i_in.byte_count;
            r_in_final <= i_in.final_req;
        end
    end

    gau_align u_align (
        .i_partial (r_partial),
        .i_fill    (r_fill),
        .i_data    (r_in_data),
        .i_count   (r_in_count),
        .o_align   (align)
    );

    // With a full block and a padded remainder in one beat,
    // Y' = (Y ^ C) * H^2 ^ L * H.
    always_comb begin
        use_sq = align.full && r_in_final && align.pending;
        mul_en = align.full || (r_in_final && align.pending);
        mul1_a = r_y ^ align.c_block;
        mul1_k = use_sq ? r_hsq : r_h;
    end

    gau_gf_mult u_mul_main (
        .i_a (mul1_a),
        .i_b (mul1_k),
        .o_p (mul1_p)
    );

    gau_gf_mult u_mul_tail (
        .i_a (align.l_block),
        .i_b (r_h),
        .o_p (mul2_p)
    );

    always_comb begin
        if (!mul_en) begin
            n_y = r_y;
        end else if (use_sq) begin
            n_y = mul1_p ^ mul2_p;
        end else begin
            n_y = mul1_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y       <= '0;
            r_partial <= '0;
            r_fill    <= 4'd0;
        end else if (advance) begin
            if (r_in_final) begin
                r_y       <= '0;
                r_partial <= '0;
                r_fill    <= 4'd0;
            end else begin
                r_y       <= n_y;
                r_partial <= align.full ? align.l_block : align.c_block;
                r_fill    <= align.new_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_final) begin
            r_out_digest <= n_y;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_high = r_out_digest[127:64];
    assign o_out.digest_low  = r_out_digest[63:0];

    // A final beat leaves no message state behind.
    a_clear_after_final : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_final |=> (r_y == '0) && (r_fill == 4'd0) && (r_partial == '0))
        else $error("message state not cleared after final beat");

    // Buffer bytes at or beyond the fill level are always zero.
    a_partial_tail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_partial & ~gau_pkg::byte_mask({1'b0, r_fill})) == '0)
        else $error("partial buffer holds bytes beyond its fill level");

    // Input stalls only behind an untaken digest.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_in_valid && r_in_final && r_out_valid && !o_out.ready)
        else $error("input stalled without a pending digest");

endmodule

`default_nettype wire
